// ===== sv/calclk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types and constants for the calendar clock counter: item and
// result payloads, configuration and calendar state, register indexes.
// ----------------------------------------------------------------------------
package calclk_pkg;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd;

    typedef logic [7:0] t_cfg_index;

    localparam t_cfg_index CFG_SECONDS_PER_MINUTE = 8'd0;
    localparam t_cfg_index CFG_LONG_MONTH_DAYS    = 8'd1;
    localparam t_cfg_index CFG_MEDIUM_MONTH_DAYS  = 8'd2;
    localparam t_cfg_index CFG_SHORT_MONTH_DAYS   = 8'd3;

    localparam logic [7:0] SPM_RESET    = 8'd60;
    localparam logic [7:0] LONG_RESET   = 8'd31;
    localparam logic [7:0] MEDIUM_RESET = 8'd30;
    localparam logic [7:0] SHORT_RESET  = 8'd28;

    localparam logic [15:0] YEAR_RESET   = 16'd2020;
    localparam logic [7:0]  HOUR_WRAPPED = 8'hFF;
    localparam logic [15:0] FRAC_MAX     = 16'hFFFF;

    localparam logic [7:0] MON_JAN = 8'd0;
    localparam logic [7:0] MON_FEB = 8'd1;
    localparam logic [7:0] MON_MAR = 8'd2;
    localparam logic [7:0] MON_APR = 8'd3;
    localparam logic [7:0] MON_MAY = 8'd4;
    localparam logic [7:0] MON_JUN = 8'd5;
    localparam logic [7:0] MON_JUL = 8'd6;
    localparam logic [7:0] MON_AUG = 8'd7;
    localparam logic [7:0] MON_SEP = 8'd8;
    localparam logic [7:0] MON_OCT = 8'd9;
    localparam logic [7:0] MON_NOV = 8'd10;
    localparam logic [7:0] MON_DEC = 8'd11;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  elapsed_seconds;
        logic [7:0]  load_minute;
        logic [7:0]  load_hour;
        logic [7:0]  load_day;
        logic [7:0]  load_month;
        logic [15:0] load_year;
    } t_calclk_in;

    typedef struct packed {
        logic [7:0]  minute_out;
        logic [7:0]  hour_out;
        logic [7:0]  day_out;
        logic [7:0]  month_out;
        logic [15:0] year_out;
        logic [31:0] total_seconds_out;
        logic [15:0] day_fraction;
    } t_calclk_out;

    typedef struct packed {
        logic [7:0] seconds_per_minute;
        logic [7:0] long_month_days;
        logic [7:0] medium_month_days;
        logic [7:0] short_month_days;
    } t_calclk_cfg;

    // Pending seconds always stay below seconds_per_minute, so 8 bits hold them.
    typedef struct packed {
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] year;
        logic [7:0]  pending;
        logic [31:0] total;
    } t_calclk_state;

endpackage

// ===== sv/calclk_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock configuration registers
// Holds the four configuration registers and decodes writes by index.
// ----------------------------------------------------------------------------
module calclk_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  calclk_pkg::t_cfg_index  i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    output calclk_pkg::t_calclk_cfg o_cfg
);

    calclk_pkg::t_calclk_cfg r_cfg;
    calclk_pkg::t_calclk_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                calclk_pkg::CFG_SECONDS_PER_MINUTE: n_cfg.seconds_per_minute = i_cfg_data;
                calclk_pkg::CFG_LONG_MONTH_DAYS:    n_cfg.long_month_days    = i_cfg_data;
                calclk_pkg::CFG_MEDIUM_MONTH_DAYS:  n_cfg.medium_month_days  = i_cfg_data;
                calclk_pkg::CFG_SHORT_MONTH_DAYS:   n_cfg.short_month_days   = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seconds_per_minute <= calclk_pkg::SPM_RESET;
            r_cfg.long_month_days    <= calclk_pkg::LONG_RESET;
            r_cfg.medium_month_days  <= calclk_pkg::MEDIUM_RESET;
            r_cfg.short_month_days   <= calclk_pkg::SHORT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/calclk_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock step logic
// Next calendar state for one item: load preset, or tick with hour
// normalisation and the minute, hour, day, month and year carries.
// ----------------------------------------------------------------------------
module calclk_step #(
    parameter int unsigned MINUTES_PER_HOUR = 60,
    parameter int unsigned HOURS_PER_DAY    = 24
) (
    input  calclk_pkg::t_calclk_cfg   i_cfg,
    input  calclk_pkg::t_calclk_state i_state,
    input  calclk_pkg::t_calclk_in    i_item,
    output calclk_pkg::t_calclk_state o_next,
    output logic                      o_frac_update
);

    localparam logic [7:0] MPH      = 8'(MINUTES_PER_HOUR);
    localparam logic [7:0] HPD      = 8'(HOURS_PER_DAY);
    localparam logic [7:0] HOUR_TOP = 8'(HOURS_PER_DAY - 1);

    logic [7:0] hour_norm;
    logic [8:0] pend_sum;
    logic [7:0] minute_inc;
    logic [7:0] hour_inc;
    logic [7:0] day_inc;
    logic [8:0] feb_limit;

    always_comb begin
        o_next        = i_state;
        o_frac_update = 1'b0;
        hour_norm     = i_state.hour;
        pend_sum      = {1'b0, i_state.pending} + {1'b0, i_item.elapsed_seconds};
        minute_inc    = i_state.minute + 8'd1;
        hour_inc      = '0;
        day_inc       = i_state.day + 8'd1;
        feb_limit     = {1'b0, i_cfg.short_month_days}
                        + {8'd0, (i_state.year[1:0] == 2'b00)};

        if (i_item.command == calclk_pkg::CMD_LOAD) begin
            o_next.minute  = i_item.load_minute;
            o_next.hour    = i_item.load_hour;
            o_next.day     = i_item.load_day;
            o_next.month   = i_item.load_month;
            o_next.year    = i_item.load_year;
            o_next.pending = '0;
            o_frac_update  = 1'b1;
        end else begin
            if (i_state.hour == calclk_pkg::HOUR_WRAPPED) begin
                hour_norm = HOUR_TOP;
            end else if (i_state.hour >= HPD) begin
                hour_norm = '0;
            end
            hour_inc    = hour_norm + 8'd1;
            o_next.hour = hour_norm;

            if (pend_sum >= {1'b0, i_cfg.seconds_per_minute}) begin
                o_frac_update  = 1'b1;
                o_next.total   = i_state.total + 32'(pend_sum);
                o_next.pending = '0;
                if (minute_inc >= MPH) begin
                    o_next.minute = '0;
                    if (hour_inc >= HPD) begin
                        o_next.hour = '0;
                        o_next.day  = day_inc;
                        // Months outside the year only let the day count run on.
                        case (i_state.month) inside
                            calclk_pkg::MON_JAN, calclk_pkg::MON_MAR, calclk_pkg::MON_MAY,
                            calclk_pkg::MON_JUL, calclk_pkg::MON_AUG, calclk_pkg::MON_OCT,
                            calclk_pkg::MON_DEC: begin
                                if (day_inc >= i_cfg.long_month_days) begin
                                    o_next.day = '0;
                                    if (i_state.month == calclk_pkg::MON_DEC) begin
                                        o_next.month = calclk_pkg::MON_JAN;
                                        o_next.year  = i_state.year + 16'd1;
                                    end else begin
                                        o_next.month = i_state.month + 8'd1;
                                    end
                                end
                            end
                            calclk_pkg::MON_APR, calclk_pkg::MON_JUN, calclk_pkg::MON_SEP,
                            calclk_pkg::MON_NOV: begin
                                if (day_inc >= i_cfg.medium_month_days) begin
                                    o_next.day   = '0;
                                    o_next.month = i_state.month + 8'd1;
                                end
                            end
                            calclk_pkg::MON_FEB: begin
                                if ({1'b0, day_inc} >= feb_limit) begin
                                    o_next.day   = '0;
                                    o_next.month = i_state.month + 8'd1;
                                end
                            end
                            default: ;
                        endcase
                    end else begin
                        o_next.hour = hour_inc;
                    end
                end else begin
                    o_next.minute = minute_inc;
                end
            end else begin
                // The sum stays below seconds_per_minute here, so it fits 8 bits.
                o_next.pending = pend_sum[7:0];
            end
        end
    end

endmodule

// ===== sv/calclk_frac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock day fraction
// Time of day as unsigned Q0.16, floor(position * 65536 / minutes per day),
// saturated at all ones. The division is an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module calclk_frac #(
    parameter int unsigned MINUTES_PER_HOUR = 60,
    parameter int unsigned HOURS_PER_DAY    = 24
) (
    input  logic [7:0]  i_minute,
    input  logic [7:0]  i_hour,
    output logic [15:0] o_fraction
);

    localparam int unsigned SPAN    = MINUTES_PER_HOUR * HOURS_PER_DAY;
    localparam int unsigned SHIFT_L = $clog2(SPAN);
    // Rounded-up reciprocal of the span scaled by 2^(32 + SHIFT_L); exact for
    // every 32-bit numerator because 2^SHIFT_L is at least the span.
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << (32 + SHIFT_L)) + 64'(SPAN) - 64'd1) / 64'(SPAN);
    localparam int unsigned MW = 34;
    localparam logic [MW-1:0] MAGIC = MAGIC_FULL[MW-1:0];
    localparam logic [15:0] SPAN16 = 16'(SPAN);

    logic [15:0]      pos;
    logic [16+MW-1:0] prod;

    assign pos  = {8'd0, i_hour} * 16'(MINUTES_PER_HOUR) + {8'd0, i_minute};
    assign prod = {{MW{1'b0}}, pos} * {16'd0, MAGIC};

    // The quotient fits 16 bits exactly when the position is below the span.
    assign o_fraction = (pos >= SPAN16) ? calclk_pkg::FRAC_MAX
                                        : prod[16 + SHIFT_L +: 16];

endmodule

// ===== sv/calendar_clock_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock counter
// Minute, hour, day, month and year counter driven by elapsed-second
// ticks, with a load command, total seconds and a Q0.16 day fraction.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_calclk_in)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_calclk_out)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle when not stalled; each result appears in the cycle after
// its item is accepted. The whole update is one combinational pass from the
// state registers into the result register, with one reciprocal multiply for
// the fraction. Reset is synchronous and restores the calendar and registers.
// o_in_ready is high while the result register is empty or being taken.
// ----------------------------------------------------------------------------
module calendar_clock_counter #(
    parameter int unsigned MINUTES_PER_HOUR = 60,
    parameter int unsigned HOURS_PER_DAY    = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  calclk_pkg::t_calclk_in  i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output calclk_pkg::t_calclk_out o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  calclk_pkg::t_cfg_index  i_cfg_index,
    input  logic [7:0]              i_cfg_data
);

    calclk_pkg::t_calclk_cfg   cfg;
    calclk_pkg::t_calclk_state r_state;
    calclk_pkg::t_calclk_state n_state;
    logic [15:0]               r_frac;
    logic [15:0]               n_frac;
    logic [15:0]               frac_calc;
    logic                      frac_update;
    logic                      in_fire;
    logic                      r_out_valid;
    logic                      n_out_valid;
    calclk_pkg::t_calclk_out   r_out;

    calclk_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    calclk_step #(
        .MINUTES_PER_HOUR (MINUTES_PER_HOUR),
        .HOURS_PER_DAY    (HOURS_PER_DAY)
    ) u_step (
        .i_cfg         (cfg),
        .i_state       (r_state),
        .i_item        (i_in_data),
        .o_next        (n_state),
        .o_frac_update (frac_update)
    );

    calclk_frac #(
        .MINUTES_PER_HOUR (MINUTES_PER_HOUR),
        .HOURS_PER_DAY    (HOURS_PER_DAY)
    ) u_frac (
        .i_minute   (n_state.minute),
        .i_hour     (n_state.hour),
        .o_fraction (frac_calc)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign n_frac      = frac_update ? frac_calc : r_frac;
    assign n_out_valid = in_fire || (r_out_valid && !i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.minute  <= '0;
            r_state.hour    <= '0;
            r_state.day     <= '0;
            r_state.month   <= calclk_pkg::MON_JAN;
            r_state.year    <= calclk_pkg::YEAR_RESET;
            r_state.pending <= '0;
            r_state.total   <= '0;
            r_frac          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                r_state <= n_state;
                r_frac  <= n_frac;
            end
        end
    end

    // The result register carries payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.minute_out        <= n_state.minute;
            r_out.hour_out          <= n_state.hour;
            r_out.day_out           <= n_state.day;
            r_out.month_out         <= n_state.month;
            r_out.year_out          <= n_state.year;
            r_out.total_seconds_out <= n_state.total;
            r_out.day_fraction      <= n_frac;
        end
    end

endmodule
